// File: rtl/brb_pkg.sv
// ----------------------------------------------------------------------------
// brb_pkg
// Shared widths, command codes, status codes and the sequencer state type
// for the byte ring buffer.
// ----------------------------------------------------------------------------
package brb_pkg;

    // Fixed field widths of the command and result ports.
    localparam int CMD_W   = 3;
    localparam int BYTE_W  = 8;
    localparam int COUNT_W = 7;
    localparam int SIZE_W  = 10;
    localparam int STAT_W  = 2;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_ENQUEUE = 3'd0;
    localparam logic [CMD_W-1:0] CMD_DEQUEUE = 3'd1;
    localparam logic [CMD_W-1:0] CMD_PEEK    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_SKIP    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_ADVANCE = 3'd4;
    localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd5;

    // Status codes.
    localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STAT_W-1:0] STAT_REFUSED = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL    = 2'd2;

    // Read run sequencer states.
    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RUN  = 2'b10
    } run_state_t;

endpackage

// File: rtl/byte_ring_buffer.sv
// ----------------------------------------------------------------------------
// byte_ring_buffer
// Byte circular FIFO that keeps one slot empty, with a programmable usable
// size, built around one synchronous byte memory.
// ----------------------------------------------------------------------------
// Usage:
//   A command (cmd, data_byte, count) is taken on a clock edge with start
//   high and busy low. Results come out on done, one per cycle, each
//   valid for exactly one cycle; the receiver always takes them.
//   Enqueue, skip, advance, clear and every refusal give one result in the
//   cycle after the command. A dequeue or peek of N bytes gives N results
//   on consecutive cycles, one memory read per cycle, and holds busy high
//   until its last memory read is issued. All other commands leave busy low,
//   so one command per cycle is taken outside read runs.
//   The occupancy fields (used, free, contiguous sizes) always show the
//   state after the whole command; they are valid while done is high.
//   The usable_size register is written through cfg_valid/cfg_ready while
//   the block is idle; a write also empties the queue. cfg_ready is low
//   while a read run is in progress and while start is high.
//   Reset empties the queue and sets the usable size to 1023. The byte
//   memory is not cleared; no read can reach an unwritten entry except
//   through advance rear.
// ----------------------------------------------------------------------------
module byte_ring_buffer
    import brb_pkg::*;
#(
    parameter int STORE_DEPTH = 1024,
    parameter int MAX_RUN     = 64
)(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [CMD_W-1:0]   cmd,
    input  logic [BYTE_W-1:0]  data_byte,
    input  logic [COUNT_W-1:0] count,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [SIZE_W-1:0]  usable_size,
    output logic               done,
    output logic [BYTE_W-1:0]  read_byte,
    output logic [STAT_W-1:0]  status,
    output logic [COUNT_W-1:0] moved,
    output logic               last,
    output logic [SIZE_W-1:0]  used_bytes,
    output logic [SIZE_W-1:0]  free_bytes,
    output logic [SIZE_W-1:0]  contiguous_write,
    output logic [SIZE_W-1:0]  contiguous_read
);

    localparam int PW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int AW = ((PW > SIZE_W) ? PW : SIZE_W) + 1;

    // Wrapping pointer step within the ring.
    function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] p,
                                               input logic [AW-1:0] n,
                                               input logic [AW-1:0] len);
        logic [AW-1:0] q;
        q = p + n;
        if (q >= len)
        begin
            q = q - len;
        end
        return q;
    endfunction

    // Byte memory.
    logic [BYTE_W-1:0] mem [STORE_DEPTH];
    logic [BYTE_W-1:0] mem_q;
    logic              mem_we;
    logic              rd_en;
    logic [PW-1:0]     rd_addr;

    // Registers.
    logic [SIZE_W-1:0]  usz_reg;
    logic [PW-1:0]      rp_reg, rp_next;
    logic [PW-1:0]      wp_reg, wp_next;
    run_state_t         state_reg, state_next;
    logic [PW-1:0]      run_addr_reg, run_addr_next;
    logic [COUNT_W-1:0] run_left_reg, run_left_next;
    logic               done_reg, done_next;
    logic [STAT_W-1:0]  status_reg, status_next;
    logic [COUNT_W-1:0] moved_reg, moved_next;
    logic               last_reg, last_next;
    logic               data_sel_reg, data_sel_next;

    // Occupancy arithmetic.
    logic [AW-1:0] usz_c, ring_len, rp_ext, wp_ext, used, free_cnt;
    logic [AW-1:0] cnt_sat, skip_n, adv_n, cw, cr;
    logic          accept, cfg_accept;

    assign busy       = (state_reg == S_RUN);
    assign cfg_ready  = !busy && !start;
    assign accept     = start && !busy;
    assign cfg_accept = cfg_valid && cfg_ready;

    // Clamp the usable size to the store and derive the ring length.
    always_comb
    begin
        usz_c = AW'(usz_reg);
        if (usz_c == '0)
        begin
            usz_c = AW'(1);
        end
        else if (usz_c > AW'(STORE_DEPTH - 1))
        begin
            usz_c = AW'(STORE_DEPTH - 1);
        end
    end

    assign ring_len = usz_c + AW'(1);
    assign rp_ext   = AW'(rp_reg);
    assign wp_ext   = AW'(wp_reg);
    assign used     = (wp_ext >= rp_ext) ? (wp_ext - rp_ext) : (ring_len - (rp_ext - wp_ext));
    assign free_cnt = usz_c - used;
    assign cnt_sat  = (count > COUNT_W'(MAX_RUN)) ? AW'(MAX_RUN) : AW'(count);
    assign skip_n   = (cnt_sat > used) ? used : cnt_sat;
    assign adv_n    = (cnt_sat > free_cnt) ? free_cnt : cnt_sat;

    // Contiguous write and read spans.
    always_comb
    begin
        if (free_cnt == '0)
        begin
            cw = '0;
        end
        else if (rp_ext <= wp_ext)
        begin
            cw = ((ring_len - wp_ext) > free_cnt) ? free_cnt : (ring_len - wp_ext);
        end
        else
        begin
            cw = rp_ext - wp_ext - AW'(1);
        end

        if (used == '0)
        begin
            cr = '0;
        end
        else if (rp_ext < wp_ext)
        begin
            cr = used;
        end
        else
        begin
            cr = ring_len - rp_ext;
        end
    end

    // Command decode and read run sequencing.
    always_comb
    begin
        rp_next       = rp_reg;
        wp_next       = wp_reg;
        state_next    = state_reg;
        run_addr_next = run_addr_reg;
        run_left_next = run_left_reg;
        done_next     = 1'b0;
        status_next   = STAT_OK;
        moved_next    = '0;
        last_next     = 1'b1;
        data_sel_next = 1'b0;
        mem_we        = 1'b0;
        rd_en         = 1'b0;
        rd_addr       = rp_reg;

        if (accept)
        begin
            done_next = 1'b1;
            case (cmd)
                CMD_ENQUEUE:
                begin
                    if (free_cnt == '0)
                    begin
                        status_next = STAT_FULL;
                    end
                    else
                    begin
                        mem_we     = 1'b1;
                        wp_next    = PW'(ring_add(wp_ext, AW'(1), ring_len));
                        moved_next = COUNT_W'(1);
                    end
                end
                CMD_DEQUEUE, CMD_PEEK:
                begin
                    if (count == '0 || count > COUNT_W'(MAX_RUN) || used < AW'(count))
                    begin
                        status_next = STAT_REFUSED;
                    end
                    else
                    begin
                        // First byte is read right away; the rest follow in the run.
                        rd_en         = 1'b1;
                        data_sel_next = 1'b1;
                        last_next     = (count == COUNT_W'(1));
                        if (cmd == CMD_DEQUEUE)
                        begin
                            rp_next = PW'(ring_add(rp_ext, AW'(count), ring_len));
                        end
                        if (count > COUNT_W'(1))
                        begin
                            state_next    = S_RUN;
                            run_addr_next = PW'(ring_add(rp_ext, AW'(1), ring_len));
                            run_left_next = count - COUNT_W'(1);
                        end
                    end
                end
                CMD_SKIP:
                begin
                    rp_next    = PW'(ring_add(rp_ext, skip_n, ring_len));
                    moved_next = COUNT_W'(skip_n);
                end
                CMD_ADVANCE:
                begin
                    wp_next    = PW'(ring_add(wp_ext, adv_n, ring_len));
                    moved_next = COUNT_W'(adv_n);
                end
                CMD_CLEAR:
                begin
                    rp_next = '0;
                    wp_next = '0;
                end
                default:
                begin
                    status_next = STAT_REFUSED;
                end
            endcase
        end
        else if (state_reg == S_RUN)
        begin
            rd_en         = 1'b1;
            rd_addr       = run_addr_reg;
            done_next     = 1'b1;
            data_sel_next = 1'b1;
            last_next     = (run_left_reg == COUNT_W'(1));
            run_addr_next = PW'(ring_add(AW'(run_addr_reg), AW'(1), ring_len));
            run_left_next = run_left_reg - COUNT_W'(1);
            if (run_left_reg == COUNT_W'(1))
            begin
                state_next = S_IDLE;
            end
        end

        // A size write empties the queue.
        if (cfg_accept)
        begin
            rp_next = '0;
            wp_next = '0;
        end
    end

    // Memory port: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wp_reg] <= data_byte;
        end
        if (rd_en)
        begin
            mem_q <= mem[rd_addr];
        end
    end

    // Control and result registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            usz_reg      <= SIZE_W'(1023);
            rp_reg       <= '0;
            wp_reg       <= '0;
            state_reg    <= S_IDLE;
            run_addr_reg <= '0;
            run_left_reg <= '0;
            done_reg     <= 1'b0;
            status_reg   <= STAT_OK;
            moved_reg    <= '0;
            last_reg     <= 1'b0;
            data_sel_reg <= 1'b0;
        end
        else
        begin
            if (cfg_accept)
            begin
                usz_reg <= usable_size;
            end
            rp_reg       <= rp_next;
            wp_reg       <= wp_next;
            state_reg    <= state_next;
            run_addr_reg <= run_addr_next;
            run_left_reg <= run_left_next;
            done_reg     <= done_next;
            status_reg   <= status_next;
            moved_reg    <= moved_next;
            last_reg     <= last_next;
            data_sel_reg <= data_sel_next;
        end
    end

    // Result outputs; occupancy reflects the pointers after the command.
    assign done             = done_reg;
    assign read_byte        = data_sel_reg ? mem_q : '0;
    assign status           = status_reg;
    assign moved            = moved_reg;
    assign last             = last_reg;
    assign used_bytes       = SIZE_W'(used);
    assign free_bytes       = SIZE_W'(free_cnt);
    assign contiguous_write = SIZE_W'(cw);
    assign contiguous_read  = SIZE_W'(cr);

    // Assertions.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_RUN |-> run_left_reg != '0)
        else $error("read run active with no bytes left");

    assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |=> done_reg && data_sel_reg)
        else $error("memory read without a data result");

    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_RUN && run_left_reg == COUNT_W'(1) |=> state_reg == S_IDLE && last_reg)
        else $error("read run did not end with a last marker");

    assert property (@(posedge clk) disable iff (!rst_n)
        rp_ext < ring_len && wp_ext < ring_len)
        else $error("pointer outside the ring");

    assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && status_reg != STAT_OK |-> last_reg && moved_reg == '0 && !data_sel_reg)
        else $error("refused transfer carries data or moved bytes");

endmodule

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for byte_ring_buffer. A queue of pending commands
// and usable size writes is built up front. A clocked driver issues them with
// random gaps and predicts every result at the transfer. A clocked monitor
// compares each done pulse field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
    import brb_pkg::*;

    localparam int STORE_DEPTH   = 1024;
    localparam int IDX_W         = $clog2(STORE_DEPTH);
    localparam int MAX_RUN       = 64;
    localparam int MAX_SIZE      = STORE_DEPTH - 1;
    localparam int SETTLE_CYCLES = 4;
    localparam int LIMIT_TIME    = 8_000_000;

    // Codes the block does not define; both must be refused.
    localparam logic [CMD_W-1:0] CMD_UNUSED_6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_UNUSED_7 = 3'd7;

    // One pending transfer: a command or a usable size write.
    typedef struct packed {
        logic               is_cfg;
        logic [CMD_W-1:0]   op;
        logic [BYTE_W-1:0]  din;
        logic [COUNT_W-1:0] cnt;
        logic [SIZE_W-1:0]  size;
        logic [6:0]         idle_pct;
    } pending_t;

    // One predicted result.
    typedef struct packed {
        logic [BYTE_W-1:0]  rbyte;
        logic [STAT_W-1:0]  stat;
        logic [COUNT_W-1:0] moved_n;
        logic               last_f;
        logic [SIZE_W-1:0]  used_n;
        logic [SIZE_W-1:0]  free_n;
        logic [SIZE_W-1:0]  cwrite;
        logic [SIZE_W-1:0]  cread;
    } ring_result_t;

    logic               clk;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [CMD_W-1:0]   cmd = '0;
    logic [BYTE_W-1:0]  data_byte = '0;
    logic [COUNT_W-1:0] count = '0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [SIZE_W-1:0]  usable_size = 10'd1023;
    logic               done;
    logic [BYTE_W-1:0]  read_byte;
    logic [STAT_W-1:0]  status;
    logic [COUNT_W-1:0] moved;
    logic               last;
    logic [SIZE_W-1:0]  used_bytes;
    logic [SIZE_W-1:0]  free_bytes;
    logic [SIZE_W-1:0]  contiguous_write;
    logic [SIZE_W-1:0]  contiguous_read;

    pending_t     pending[$];
    ring_result_t expected_results[$];
    int           errors = 0;
    int           outstanding = 0;
    int           quiet_cycles = 0;

    // Ring state as seen at the transfers.
    logic [BYTE_W-1:0] byte_mem [STORE_DEPTH];
    int unsigned       live_rd = 0;
    int unsigned       live_wr = 0;
    int unsigned       live_size = 1023;

    // Ring state while the stimulus is planned; tracks which entries hold data.
    bit                plan_known [STORE_DEPTH];
    int unsigned       plan_rd = 0;
    int unsigned       plan_wr = 0;
    int unsigned       plan_size = 1023;

    byte_ring_buffer #(
        .STORE_DEPTH (STORE_DEPTH),
        .MAX_RUN     (MAX_RUN)
    ) uut (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .cmd              (cmd),
        .data_byte        (data_byte),
        .count            (count),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .usable_size      (usable_size),
        .done             (done),
        .read_byte        (read_byte),
        .status           (status),
        .moved            (moved),
        .last             (last),
        .used_bytes       (used_bytes),
        .free_bytes       (free_bytes),
        .contiguous_write (contiguous_write),
        .contiguous_read  (contiguous_read)
    );

    // Clock generation.
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic int unsigned min_u(input int unsigned a, input int unsigned b);
        return (a < b) ? a : b;
    endfunction

    // Ring length for a usable size; zero acts as one, the top is capped.
    function automatic int unsigned ring_len(input int unsigned sz);
        int unsigned u;
        u = (sz == 0) ? 1 : sz;
        if (u > MAX_SIZE)
            u = MAX_SIZE;
        return u + 1;
    endfunction

    function automatic int unsigned ring_next(input int unsigned p, input int unsigned n,
                                              input int unsigned sz);
        int unsigned q;
        q = p + n;
        if (q >= ring_len(sz))
            q -= ring_len(sz);
        return q;
    endfunction

    function automatic int unsigned used_of(input int unsigned rd, input int unsigned wr,
                                            input int unsigned sz);
        if (wr >= rd)
            return wr - rd;
        return ring_len(sz) - (rd - wr);
    endfunction

    function automatic int unsigned free_of(input int unsigned rd, input int unsigned wr,
                                            input int unsigned sz);
        return ring_len(sz) - 1 - used_of(rd, wr, sz);
    endfunction

    // Pointer effect of one command, with its status, moved count and the
    // number of results it gives.
    function automatic void apply_cmd(input logic [CMD_W-1:0] op, input int unsigned cnt,
                                      input int unsigned sz, inout int unsigned rd,
                                      inout int unsigned wr, output logic [STAT_W-1:0] st,
                                      output int unsigned mv, output int unsigned nres);
        int unsigned n;
        st   = STAT_OK;
        mv   = 0;
        nres = 1;
        case (op)
            CMD_ENQUEUE:
            begin
                if (free_of(rd, wr, sz) == 0)
                    st = STAT_FULL;
                else
                begin
                    wr = ring_next(wr, 1, sz);
                    mv = 1;
                end
            end
            CMD_DEQUEUE, CMD_PEEK:
            begin
                if (cnt == 0 || cnt > MAX_RUN || used_of(rd, wr, sz) < cnt)
                    st = STAT_REFUSED;
                else
                begin
                    nres = cnt;
                    if (op == CMD_DEQUEUE)
                        rd = ring_next(rd, cnt, sz);
                end
            end
            CMD_SKIP:
            begin
                n  = min_u(min_u(cnt, MAX_RUN), used_of(rd, wr, sz));
                rd = ring_next(rd, n, sz);
                mv = n;
            end
            CMD_ADVANCE:
            begin
                n  = min_u(min_u(cnt, MAX_RUN), free_of(rd, wr, sz));
                wr = ring_next(wr, n, sz);
                mv = n;
            end
            CMD_CLEAR:
            begin
                rd = 0;
                wr = 0;
            end
            default:
                st = STAT_REFUSED;
        endcase
    endfunction

    // Predicts the results of a command taken now and returns how many.
    function automatic int unsigned predict_results(input logic [CMD_W-1:0] op,
                                                    input logic [BYTE_W-1:0] din,
                                                    input logic [COUNT_W-1:0] cnt);
        int unsigned  old_rd, old_wr, len, used, fr, cw, cr, mv, nres, p, i;
        logic [STAT_W-1:0] st;
        ring_result_t r;
        old_rd = live_rd;
        old_wr = live_wr;
        apply_cmd(op, 32'(cnt), live_size, live_rd, live_wr, st, mv, nres);
        if (op == CMD_ENQUEUE && mv == 1)
            byte_mem[old_wr[IDX_W-1:0]] = din;

        // Occupancy after the whole command.
        len  = ring_len(live_size);
        used = used_of(live_rd, live_wr, live_size);
        fr   = free_of(live_rd, live_wr, live_size);
        if (fr == 0)
            cw = 0;
        else if (live_rd <= live_wr)
            cw = min_u(len - live_wr, fr);
        else
            cw = live_rd - live_wr - 1;
        if (used == 0)
            cr = 0;
        else if (live_rd < live_wr)
            cr = used;
        else
            cr = len - live_rd;

        // Reads deliver one byte per result starting at the old front.
        p = old_rd;
        for (i = 0; i < nres; i++)
        begin
            r.rbyte   = (st == STAT_OK && (op == CMD_DEQUEUE || op == CMD_PEEK)) ?
                        byte_mem[p[IDX_W-1:0]] : '0;
            r.stat    = st;
            r.moved_n = COUNT_W'(mv);
            r.last_f  = (i + 1 == nres);
            r.used_n  = SIZE_W'(used);
            r.free_n  = SIZE_W'(fr);
            r.cwrite  = SIZE_W'(cw);
            r.cread   = SIZE_W'(cr);
            expected_results.push_back(r);
            p = ring_next(p, 1, live_size);
        end
        return nres;
    endfunction

    // Queues one command. A successful read that would reach an entry never
    // written is shortened to the written part, or turned into a skip.
    function automatic void queue_command(input logic [CMD_W-1:0] op,
                                          input logic [BYTE_W-1:0] din,
                                          input int unsigned cnt, input int unsigned idle);
        int unsigned k, p, old_wr, mv, nres;
        logic [STAT_W-1:0] st;
        pending_t it;
        if ((op == CMD_DEQUEUE || op == CMD_PEEK) && cnt != 0 && cnt <= MAX_RUN &&
            used_of(plan_rd, plan_wr, plan_size) >= cnt)
        begin
            k = 0;
            p = plan_rd;
            while (k < cnt && plan_known[p[IDX_W-1:0]])
            begin
                k++;
                p = ring_next(p, 1, plan_size);
            end
            if (k == 0)
                op = CMD_SKIP;
            else
                cnt = k;
        end
        old_wr = plan_wr;
        apply_cmd(op, cnt, plan_size, plan_rd, plan_wr, st, mv, nres);
        if (op == CMD_ENQUEUE && mv == 1)
            plan_known[old_wr[IDX_W-1:0]] = 1'b1;
        it.is_cfg   = 1'b0;
        it.op       = op;
        it.din      = din;
        it.cnt      = COUNT_W'(cnt);
        it.size     = '0;
        it.idle_pct = 7'(idle);
        pending.push_back(it);
    endfunction

    function automatic void queue_size_write(input int unsigned sz);
        pending_t it;
        it          = '0;
        it.is_cfg   = 1'b1;
        it.size     = SIZE_W'(sz);
        pending.push_back(it);
        plan_size = sz;
        plan_rd   = 0;
        plan_wr   = 0;
    endfunction

    // Run length for reads: mostly one that succeeds, sometimes anything.
    function automatic int unsigned read_run(input int unsigned used);
        if (used != 0 && $urandom_range(4, 0) != 0)
            return $urandom_range(min_u(used, MAX_RUN), 1);
        return $urandom_range(127, 0);
    endfunction

    function automatic int unsigned move_run();
        if ($urandom_range(3, 0) == 0)
            return $urandom_range(127, 0);
        return $urandom_range(8, 0);
    endfunction

    // One random phase at a given usable size and sender idle rate.
    function automatic void random_phase(input int unsigned sz, input int unsigned n_items,
                                         input int unsigned idle);
        int unsigned sel, used, j;
        logic [CMD_W-1:0] odd_op;
        queue_size_write(sz);
        for (j = 0; j < n_items; j++)
        begin
            sel  = $urandom_range(99, 0);
            used = used_of(plan_rd, plan_wr, plan_size);
            if (sel < 45)
                queue_command(CMD_ENQUEUE, BYTE_W'($urandom_range(255, 0)),
                              $urandom_range(127, 0), idle);
            else if (sel < 63)
                queue_command(CMD_DEQUEUE, BYTE_W'($urandom_range(255, 0)),
                              read_run(used), idle);
            else if (sel < 72)
                queue_command(CMD_PEEK, BYTE_W'($urandom_range(255, 0)),
                              read_run(used), idle);
            else if (sel < 81)
                queue_command(CMD_SKIP, BYTE_W'($urandom_range(255, 0)), move_run(), idle);
            else if (sel < 89)
                queue_command(CMD_ADVANCE, BYTE_W'($urandom_range(255, 0)), move_run(), idle);
            else if (sel < 93)
                queue_command(CMD_CLEAR, BYTE_W'($urandom_range(255, 0)),
                              $urandom_range(127, 0), idle);
            else if (sel < 96)
            begin
                odd_op = $urandom_range(1, 0) ? CMD_UNUSED_7 : CMD_UNUSED_6;
                queue_command(odd_op, BYTE_W'($urandom_range(255, 0)),
                              $urandom_range(127, 0), idle);
            end
            else
            begin
                // A burst of enqueues followed by one read run.
                repeat ($urandom_range(12, 2))
                    queue_command(CMD_ENQUEUE, BYTE_W'($urandom_range(255, 0)),
                                  $urandom_range(127, 0), idle);
                queue_command(CMD_DEQUEUE, BYTE_W'($urandom_range(255, 0)),
                              read_run(used_of(plan_rd, plan_wr, plan_size)), idle);
            end
        end
    endfunction

    // Driver: issues pending transfers and predicts results at each command
    // transfer. Size writes wait until the block has gone quiet.
    always @(posedge clk or negedge rst_n)
    begin
        pending_t    head;
        int unsigned added;
        logic        nstart;
        logic        ncfg;
        if (!rst_n)
        begin
            start        <= 1'b0;
            cfg_valid    <= 1'b0;
            outstanding  <= 0;
            quiet_cycles <= 0;
        end
        else
        begin
            added  = 0;
            nstart = start;
            ncfg   = cfg_valid;
            if (start && !busy)
            begin
                added  = predict_results(cmd, data_byte, count);
                nstart = 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                live_size = 32'(usable_size);
                live_rd   = 0;
                live_wr   = 0;
                ncfg      = 1'b0;
            end
            if (!nstart && !ncfg && pending.size() != 0)
            begin
                head = pending[0];
                if (head.is_cfg)
                begin
                    if (quiet_cycles >= SETTLE_CYCLES)
                    begin
                        void'(pending.pop_front());
                        ncfg = 1'b1;
                        usable_size <= head.size;
                    end
                end
                else if ($urandom_range(99, 0) >= 32'(head.idle_pct))
                begin
                    void'(pending.pop_front());
                    nstart = 1'b1;
                    cmd       <= head.op;
                    data_byte <= head.din;
                    count     <= head.cnt;
                end
            end
            start        <= nstart;
            cfg_valid    <= ncfg;
            outstanding  <= outstanding + added - (done ? 1 : 0);
            quiet_cycles <= (outstanding == 0 && added == 0 && !start && !busy && !done) ?
                            quiet_cycles + 1 : 0;
        end
    end

    task automatic check_field(input string what, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s expected %0d actual %0d", $time, what, want, got);
            errors++;
        end
    endtask

    // Monitor: every done pulse is compared with the oldest prediction.
    always @(posedge clk)
    begin
        ring_result_t want;
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: result with none expected, read_byte %0d status %0d",
                         $time, read_byte, status);
                errors++;
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("read_byte", 32'(want.rbyte), 32'(read_byte));
                check_field("status", 32'(want.stat), 32'(status));
                check_field("moved", 32'(want.moved_n), 32'(moved));
                check_field("last", 32'(want.last_f), 32'(last));
                check_field("used_bytes", 32'(want.used_n), 32'(used_bytes));
                check_field("free_bytes", 32'(want.free_n), 32'(free_bytes));
                check_field("contiguous_write", 32'(want.cwrite), 32'(contiguous_write));
                check_field("contiguous_read", 32'(want.cread), 32'(contiguous_read));
            end
        end
    end

    // Stimulus plan, reset and end of run.
    initial
    begin
        // Directed part at the reset size: refusals, both byte extremes,
        // saturation of long runs, unused codes and clear.
        queue_command(CMD_DEQUEUE, 8'h00, 1, 0);
        queue_command(CMD_PEEK, 8'hFF, 0, 0);
        queue_command(CMD_ENQUEUE, 8'h00, 0, 0);
        queue_command(CMD_ENQUEUE, 8'hFF, 127, 0);
        queue_command(CMD_ENQUEUE, 8'h5A, 0, 0);
        queue_command(CMD_ENQUEUE, 8'hA5, 0, 0);
        queue_command(CMD_PEEK, 8'h00, 4, 0);
        queue_command(CMD_DEQUEUE, 8'h00, 0, 0);
        queue_command(CMD_DEQUEUE, 8'h00, 127, 0);
        queue_command(CMD_DEQUEUE, 8'h00, 5, 0);
        queue_command(CMD_DEQUEUE, 8'h00, 2, 0);
        queue_command(CMD_SKIP, 8'h00, 127, 0);
        queue_command(CMD_ADVANCE, 8'h00, 127, 0);
        queue_command(CMD_SKIP, 8'h00, 64, 0);
        queue_command(CMD_UNUSED_6, 8'hFF, 127, 0);
        queue_command(CMD_UNUSED_7, 8'h00, 0, 0);
        queue_command(CMD_ENQUEUE, 8'h3C, 0, 0);
        queue_command(CMD_CLEAR, 8'h00, 0, 0);

        // Smallest ring: full drop, wrap and clamped advance.
        queue_size_write(1);
        queue_command(CMD_ENQUEUE, 8'h81, 0, 0);
        queue_command(CMD_ENQUEUE, 8'h7E, 0, 0);
        queue_command(CMD_PEEK, 8'h00, 1, 0);
        queue_command(CMD_DEQUEUE, 8'h00, 1, 0);
        queue_command(CMD_ADVANCE, 8'h00, 3, 0);

        // A usable size of zero acts as one.
        queue_size_write(0);
        queue_command(CMD_ENQUEUE, 8'h42, 0, 0);
        queue_command(CMD_ENQUEUE, 8'h24, 0, 0);
        queue_command(CMD_DEQUEUE, 8'h00, 1, 0);

        // Random phases; sender idles 24, then 82, then never.
        random_phase(13, 55, 24);
        random_phase(1023, 55, 24);
        random_phase(2, 55, 82);
        random_phase(64, 55, 82);
        random_phase(1, 55, 0);
        random_phase(200, 55, 0);

        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (pending.size() != 0 || start || cfg_valid || outstanding != 0)
            @(posedge clk);
        repeat (2 * SETTLE_CYCLES) @(posedge clk);

        if (expected_results.size() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, expected_results.size());
            errors++;
        end
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Run limit.
    initial
    begin
        #(LIMIT_TIME);
        $display("%0t: run limit reached", $time);
        $display("tb: failure");
        $finish;
    end

endmodule
